>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the grid bucket offset index RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define CHK_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Expression must never be true outside reset.
`define CHK_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");

`else

`define CHK_ALWAYS(lbl, clk, rst, prop)
`define CHK_NEVER(lbl, clk, rst, expr)

`endif

`endif

>>> design/gboi_pkg.sv
// ---------------------------------------------------------------------------
// gboi_pkg
// Types, codes and defaults shared by the grid bucket offset index.
// ---------------------------------------------------------------------------
package gboi_pkg;

   // defaults for the top-level parameters
   localparam int MAX_CELLS_DEF   = 4096;
   localparam int MAX_ENTRIES_DEF = 1024;
   localparam int DIM_MAX_DEF     = 16;

   // fixed field widths
   localparam int KIND_W = 2;
   localparam int LOC_W  = 4;
   localparam int SIZE_W = 5;
   localparam int RNG_W  = 11;
   localparam int STAT_W = 2;
   localparam int CSR_IDX_W = 2;
   // x + sx*(y + sy*z) with 5-bit extents and 4-bit coordinates
   localparam int INNER_W = 10;
   localparam int LIN_W   = 16;

   localparam int QUEUE_DEPTH = 2;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

   // response status
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z = 2'd2;

   // commands from front to back
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;
   localparam logic [1:0] CMD_REPLY = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [LOC_W-1:0]  loc_x;
      logic [LOC_W-1:0]  loc_y;
      logic [LOC_W-1:0]  loc_z;
   } req_type;

   typedef struct packed {
      logic [RNG_W-1:0]  range_begin;
      logic [RNG_W-1:0]  range_end;
      logic              has_entries;
      logic [STAT_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [STAT_W-1:0] status;
   } cmd_type;

   localparam int CMD_W = $bits(cmd_type);

endpackage

>>> design/gboi_front.sv
// ---------------------------------------------------------------------------
// gboi_front
// Extent registers, cell linearization and request classification.
// ---------------------------------------------------------------------------
module gboi_front #(
   parameter int MAX_CELLS = gboi_pkg::MAX_CELLS_DEF,
   parameter int DIM_MAX   = gboi_pkg::DIM_MAX_DEF,
   localparam int CELL_W   = $clog2(MAX_CELLS + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [gboi_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gboi_pkg::SIZE_W-1:0]      csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  gboi_pkg::req_type                req_payload,
   input  logic                             boot_busy,
   output logic                             push,
   input  logic                             q_full,
   output gboi_pkg::cmd_type                push_cmd,
   output logic [CELL_W-1:0]                push_cell
);
   import gboi_pkg::*;

   logic [SIZE_W-1:0]  size_x_ff, size_x_in;
   logic [SIZE_W-1:0]  size_y_ff, size_y_in;
   logic [SIZE_W-1:0]  size_z_ff, size_z_in;
   logic [SIZE_W-1:0]  wdata_sat;

   logic               stg_v_ff, stg_v_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [LOC_W-1:0]   x_ff, x_in;
   logic               coord_ok_ff, coord_ok_in;
   logic [INNER_W-1:0] inner_ff, inner_in;

   logic               accept;
   logic [LIN_W-1:0]   lin;
   logic               in_range;

   // extent registers, saturated to DIM_MAX
   assign wdata_sat = (32'(csr_wdata) > DIM_MAX) ? SIZE_W'(DIM_MAX) : csr_wdata;

   always_comb begin
      size_x_in = size_x_ff;
      size_y_in = size_y_ff;
      size_z_in = size_z_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SIZE_X: size_x_in = wdata_sat;
            CSR_SIZE_Y: size_y_in = wdata_sat;
            CSR_SIZE_Z: size_z_in = wdata_sat;
            default:    ;
         endcase
      end
   end

   // stage 1: bounds check and y + sy*z
   assign push      = stg_v_ff && !q_full;
   assign req_ready = !boot_busy && (!stg_v_ff || push);
   assign accept    = req_valid && req_ready;

   always_comb begin
      stg_v_in    = push ? 1'b0 : stg_v_ff;
      kind_in     = kind_ff;
      x_in        = x_ff;
      coord_ok_in = coord_ok_ff;
      inner_in    = inner_ff;
      if (accept) begin
         stg_v_in    = 1'b1;
         kind_in     = req_payload.kind;
         x_in        = req_payload.loc_x;
         coord_ok_in = ({1'b0, req_payload.loc_x} < size_x_ff)
                    && ({1'b0, req_payload.loc_y} < size_y_ff)
                    && ({1'b0, req_payload.loc_z} < size_z_ff);
         inner_in    = INNER_W'(req_payload.loc_y)
                     + INNER_W'(size_y_ff) * INNER_W'(req_payload.loc_z);
      end
   end

   // stage 2: x + sx*inner, classify
   assign lin      = LIN_W'(x_ff) + LIN_W'(size_x_ff) * LIN_W'(inner_ff);
   assign in_range = coord_ok_ff && ({1'b0, lin} < (LIN_W + 1)'(MAX_CELLS));
   assign push_cell = CELL_W'(lin);

   always_comb begin
      push_cmd.op     = CMD_REPLY;
      push_cmd.status = STAT_OK;
      unique case (kind_ff)
         KIND_CLEAR: push_cmd.op = CMD_CLEAR;
         KIND_ADD: begin
            if (in_range) push_cmd.op = CMD_ADD;
            else          push_cmd.status = STAT_RANGE;
         end
         KIND_QUERY: begin
            if (in_range) push_cmd.op = CMD_QUERY;
            else          push_cmd.status = STAT_RANGE;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_W'(1);
         size_y_ff <= SIZE_W'(1);
         size_z_ff <= SIZE_W'(1);
         stg_v_ff  <= 1'b0;
      end else begin
         size_x_ff <= size_x_in;
         size_y_ff <= size_y_in;
         size_z_ff <= size_z_in;
         stg_v_ff  <= stg_v_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      x_ff        <= x_in;
      coord_ok_ff <= coord_ok_in;
      inner_ff    <= inner_in;
   end

endmodule

>>> design/gboi_queue.sv
// ---------------------------------------------------------------------------
// gboi_queue
// Small command queue between the front and back sections.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gboi_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = gboi_pkg::QUEUE_DEPTH,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] wdata,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output logic [DATA_W-1:0] rdata
);
   import gboi_pkg::*;

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   assign full      = (cnt_ff == CNT_W'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign rdata     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop)      cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= wdata;
   end

   `CHK_ALWAYS(a_cnt_bound, clock, reset, cnt_ff <= CNT_W'(DEPTH))
   `CHK_NEVER(a_pop_empty, clock, reset, pop && !not_empty)
   `CHK_NEVER(a_push_full, clock, reset, push && full)
   `CHK_ALWAYS(a_cnt_up, clock, reset, (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1))

endmodule

>>> design/gboi_back.sv
// ---------------------------------------------------------------------------
// gboi_back
// Offset table memory, entry count, sweeps and response register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gboi_back #(
   parameter int MAX_CELLS   = gboi_pkg::MAX_CELLS_DEF,
   parameter int MAX_ENTRIES = gboi_pkg::MAX_ENTRIES_DEF,
   localparam int CELL_W     = $clog2(MAX_CELLS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_not_empty,
   input  gboi_pkg::cmd_type   q_cmd,
   input  logic [CELL_W-1:0]   q_cell,
   output logic                pop,
   output logic                boot_busy,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output gboi_pkg::rsp_type   rsp_payload
);
   import gboi_pkg::*;

   localparam int OFS_W = $clog2(MAX_ENTRIES + 1);
   localparam logic [CELL_W-1:0] LAST = CELL_W'(MAX_CELLS);

   localparam logic [2:0] ST_WIPE = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_ADD  = 3'd2;
   localparam logic [2:0] ST_QLO  = 3'd3;
   localparam logic [2:0] ST_QHI  = 3'd4;

   logic [OFS_W-1:0]  ofs_mem [MAX_CELLS + 1];
   logic [OFS_W-1:0]  rd_data_ff;

   logic [2:0]        state_ff, state_in;
   logic [CELL_W-1:0] ptr_ff, ptr_in;
   logic [OFS_W-1:0]  cnt_ff, cnt_in;
   logic [OFS_W-1:0]  beg_ff, beg_in;
   logic              boot_ff, boot_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              rd_en, wr_en, load;
   logic [CELL_W-1:0] rd_addr, wr_addr;
   logic [OFS_W-1:0]  wr_data;
   rsp_type           res;

   assign pop = (state_ff == ST_IDLE) && q_not_empty && (!rsp_valid_ff || rsp_ready);
   assign boot_busy   = boot_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in = state_ff;
      ptr_in   = ptr_ff;
      cnt_in   = cnt_ff;
      beg_in   = beg_ff;
      boot_in  = boot_ff;
      rd_en    = 1'b0;
      rd_addr  = ptr_ff;
      wr_en    = 1'b0;
      wr_addr  = ptr_ff;
      wr_data  = '0;
      load     = 1'b0;
      res      = '0;
      unique case (state_ff)
         ST_WIPE: begin
            wr_en = 1'b1;
            if (ptr_ff == LAST) begin
               state_in = ST_IDLE;
               boot_in  = 1'b0;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (pop) begin
               unique case (q_cmd.op)
                  CMD_CLEAR: begin
                     load     = 1'b1;
                     cnt_in   = '0;
                     ptr_in   = '0;
                     state_in = ST_WIPE;
                  end
                  CMD_ADD: begin
                     load = 1'b1;
                     if (cnt_ff == OFS_W'(MAX_ENTRIES)) begin
                        res.status = STAT_FULL;
                     end else begin
                        cnt_in   = cnt_ff + 1'b1;
                        rd_en    = 1'b1;
                        rd_addr  = q_cell + 1'b1;
                        ptr_in   = q_cell + 1'b1;
                        state_in = ST_ADD;
                     end
                  end
                  CMD_QUERY: begin
                     rd_en    = 1'b1;
                     rd_addr  = q_cell;
                     ptr_in   = q_cell + 1'b1;
                     state_in = ST_QLO;
                  end
                  CMD_REPLY: begin
                     load       = 1'b1;
                     res.status = q_cmd.status;
                  end
                  default: ;
               endcase
            end
         end
         ST_ADD: begin
            // read-modify-write, one word per cycle up to the last offset
            wr_en   = 1'b1;
            wr_data = rd_data_ff + 1'b1;
            if (ptr_ff == LAST) begin
               state_in = ST_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff + 1'b1;
               ptr_in  = ptr_ff + 1'b1;
            end
         end
         ST_QLO: begin
            beg_in   = rd_data_ff;
            rd_en    = 1'b1;
            state_in = ST_QHI;
         end
         ST_QHI: begin
            load            = 1'b1;
            res.range_begin = RNG_W'(beg_ff);
            res.range_end   = RNG_W'(rd_data_ff);
            res.has_entries = (rd_data_ff > beg_ff);
            state_in        = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         ptr_ff       <= '0;
         cnt_ff       <= '0;
         boot_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         cnt_ff       <= cnt_in;
         boot_ff      <= boot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      beg_ff <= beg_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) ofs_mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= ofs_mem[rd_addr];
   end

   `CHK_ALWAYS(a_cnt_max, clock, reset, cnt_ff <= OFS_W'(MAX_ENTRIES))
   `CHK_NEVER(a_pop_busy, clock, reset, pop && boot_ff)
   `CHK_ALWAYS(a_add_end, clock, reset, (state_ff == ST_ADD && ptr_ff == LAST) |=> (state_ff == ST_IDLE))
   `CHK_ALWAYS(a_qhi_load, clock, reset, (state_ff == ST_QLO) |=> (state_ff == ST_QHI && !rsp_valid_ff))

endmodule

>>> design/grid_bucket_offset_index_core.sv
// ---------------------------------------------------------------------------
// grid_bucket_offset_index_core
// Bucket start-offset table over a 3-D grid, row-pointer style.
// ---------------------------------------------------------------------------
// Use:
//  - csr_we/csr_index/csr_wdata set the grid extents (size_x, size_y,
//    size_z; reset 1 each, saturated to DIM_MAX). Write only while idle.
//  - req_* beats carry kind (clear, add, query) and a cell coordinate.
//    Every request beat yields exactly one rsp_* beat, in order.
//  - A request beat passes the front stage and the command queue; the back
//    section answers it on the pop, or for a query in ST_QHI.
//  - Throughput is set by the back section's sweep over the offset memory
//    (one word per cycle): a query holds it through ST_QLO and ST_QHI, an
//    add at linear cell c sweeps the words from c + 1 up to MAX_CELLS,
//    a clear all words from 0 to MAX_CELLS.
//  - The front section (one register stage) and a 2-deep command queue
//    keep taking request beats while the back section sweeps.
//  - After reset the offset memory is zeroed by a clearing pass over all
//    MAX_CELLS + 1 words; req_ready stays low until it ends. Extent
//    writes are taken during the pass.
//  - When rsp_ready is low the response register holds its beat; the back
//    section waits before starting the next command, and backpressure
//    reaches req_ready once the queue and the front stage are full.
// ---------------------------------------------------------------------------
module grid_bucket_offset_index_core #(
   parameter int MAX_CELLS   = gboi_pkg::MAX_CELLS_DEF,
   parameter int MAX_ENTRIES = gboi_pkg::MAX_ENTRIES_DEF,
   parameter int DIM_MAX     = gboi_pkg::DIM_MAX_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            csr_we,
   input  logic [gboi_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gboi_pkg::SIZE_W-1:0]     csr_wdata,
   // requests
   input  logic                            req_valid,
   output logic                            req_ready,
   input  gboi_pkg::req_type               req_payload,
   // responses
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output gboi_pkg::rsp_type               rsp_payload
);
   import gboi_pkg::*;

   localparam int CELL_W = $clog2(MAX_CELLS + 1);
   localparam int QD_W   = CMD_W + CELL_W;

   // front -> queue
   logic              push;
   logic              q_full;
   cmd_type           push_cmd;
   logic [CELL_W-1:0] push_cell;

   // queue -> back
   logic              pop;
   logic              q_not_empty;
   logic [QD_W-1:0]   q_rdata;
   cmd_type           q_cmd;
   logic [CELL_W-1:0] q_cell;

   // back holds off requests during the post-reset clearing pass
   logic              boot_busy;

   assign q_cmd  = cmd_type'(q_rdata[QD_W-1 -: CMD_W]);
   assign q_cell = q_rdata[CELL_W-1:0];

   // Front: extent registers, linearization, range check, classification.
   gboi_front #(
      .MAX_CELLS (MAX_CELLS),
      .DIM_MAX   (DIM_MAX)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .boot_busy   (boot_busy),
      .push        (push),
      .q_full      (q_full),
      .push_cmd    (push_cmd),
      .push_cell   (push_cell)
   );

   // Command queue decoupling classification from table work.
   gboi_queue #(
      .DATA_W (QD_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wdata     ({push_cmd, push_cell}),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .rdata     (q_rdata)
   );

   // Back: offset memory, entry count, sweeps, response register.
   gboi_back #(
      .MAX_CELLS   (MAX_CELLS),
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_cmd       (q_cmd),
      .q_cell      (q_cell),
      .pop         (pop),
      .boot_busy   (boot_busy),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> sim/gboi_resp_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gboi_resp_checker
// Watches the request, response and register ports of the bucket offset
// index, keeps its own offset table and grid extents, and compares each
// response beat field by field with the oldest predicted range.
// ---------------------------------------------------------------------------
module gboi_resp_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [gboi_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gboi_pkg::SIZE_W-1:0]    csr_wdata,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  gboi_pkg::req_type              req_payload,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  gboi_pkg::rsp_type              rsp_payload,
   output int                             fail_count,
   output int                             pending,
   output int                             checked,
   output int                             full_seen
);
   import gboi_pkg::*;

   // keep the log short when things go badly wrong; counting goes on
   localparam int PRINT_CAP = 100;

   logic [RNG_W-1:0]  ofs_tab [0:MAX_CELLS_DEF];
   logic [RNG_W-1:0]  n_entries;
   logic [SIZE_W-1:0] ext_x, ext_y, ext_z;
   rsp_type           ranges_due [$];

   task automatic report_mismatch(input string what, input int got, input int want);
      if (fail_count < PRINT_CAP)
         $display("%0t ns mismatch: %s got %0d want %0d", $time, what, got, want);
      fail_count++;
   endtask

   // linear cell index; false when the cell lies outside the grid
   function automatic bit locate_cell(input req_type rq, output int lin);
      lin = int'(rq.loc_x) + int'(ext_x) * (int'(rq.loc_y) + int'(ext_y) * int'(rq.loc_z));
      return (rq.loc_x < ext_x) && (rq.loc_y < ext_y) && (rq.loc_z < ext_z) &&
             (lin < MAX_CELLS_DEF);
   endfunction

   // apply one request beat to the table and queue the range it returns
   task automatic step_offsets(input req_type rq);
      rsp_type r;
      int      lin;
      r = '0;
      case (rq.kind)
         KIND_CLEAR: begin
            for (int i = 0; i <= MAX_CELLS_DEF; i++)
               ofs_tab[i] = '0;
            n_entries = '0;
         end
         KIND_ADD: begin
            if (!locate_cell(rq, lin)) begin
               r.status = STAT_RANGE;
            end else if (n_entries >= MAX_ENTRIES_DEF) begin
               r.status = STAT_FULL;
               full_seen++;
            end else begin
               for (int i = lin + 1; i <= MAX_CELLS_DEF; i++)
                  ofs_tab[i] = ofs_tab[i] + 1'b1;
               n_entries = n_entries + 1'b1;
            end
         end
         KIND_QUERY: begin
            if (!locate_cell(rq, lin)) begin
               r.status = STAT_RANGE;
            end else begin
               r.range_begin = ofs_tab[lin];
               r.range_end   = ofs_tab[lin + 1];
               r.has_entries = (ofs_tab[lin + 1] > ofs_tab[lin]);
            end
         end
         default: ;
      endcase
      ranges_due.push_back(r);
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      logic [SIZE_W-1:0] v;
      if (reset) begin
         for (int i = 0; i <= MAX_CELLS_DEF; i++)
            ofs_tab[i] = '0;
         n_entries = '0;
         ext_x = 5'd1;
         ext_y = 5'd1;
         ext_z = 5'd1;
         ranges_due.delete();
         pending = 0;
         fail_count = 0;
         checked = 0;
         full_seen = 0;
      end else begin
         // response first: a beat can never match a request of the same edge
         if (rsp_valid && rsp_ready) begin
            if (ranges_due.size() == 0) begin
               report_mismatch("response beat with nothing due", 1, 0);
            end else begin
               want = ranges_due.pop_front();
               if (rsp_payload.range_begin !== want.range_begin)
                  report_mismatch("range_begin", int'(rsp_payload.range_begin),
                                  int'(want.range_begin));
               if (rsp_payload.range_end !== want.range_end)
                  report_mismatch("range_end", int'(rsp_payload.range_end),
                                  int'(want.range_end));
               if (rsp_payload.has_entries !== want.has_entries)
                  report_mismatch("has_entries", int'(rsp_payload.has_entries),
                                  int'(want.has_entries));
               if (rsp_payload.status !== want.status)
                  report_mismatch("status", int'(rsp_payload.status), int'(want.status));
               checked++;
            end
         end
         if (csr_we) begin
            v = (csr_wdata > DIM_MAX_DEF) ? SIZE_W'(DIM_MAX_DEF) : csr_wdata;
            case (csr_index)
               CSR_SIZE_X: ext_x = v;
               CSR_SIZE_Y: ext_y = v;
               CSR_SIZE_Z: ext_z = v;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            step_offsets(req_payload);
         pending = ranges_due.size();
      end
   end

endmodule

>>> sim/grid_bucket_offset_index_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grid_bucket_offset_index_core_test
// Drives clear, add, query and unused-kind beats into the bucket offset
// index under several grid extents, with bursty requests and a stalling
// response side; a side checker predicts and compares every response.
// ---------------------------------------------------------------------------
module grid_bucket_offset_index_core_test;
   import gboi_pkg::*;

   // the one request kind the block answers without touching the table
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   localparam int FILL_ADDS   = 12;                   // short top-row sweeps
   localparam int RAND_PHASES = 5;
   localparam int RAND_ITEMS  = 20;                   // per phase
   localparam int TAIL_CYCLES = 8;                    // quiet cycles after the last response

   typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_MOSTLY, RDY_PATTERN} rdy_mode_type;

   // all block inputs known from time zero
   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [SIZE_W-1:0]    csr_wdata   = '0;
   logic                 req_valid   = 1'b0;
   req_type              req_payload = '0;
   logic                 rsp_ready   = 1'b0;
   logic                 req_ready;
   logic                 rsp_valid;
   rsp_type              rsp_payload;

   int n_fail, n_due, n_checked, n_full;

   // stimulus bookkeeping
   int          eff_x = 1, eff_y = 1, eff_z = 1;  // extents after saturation
   logic [3:0]  last_x = '0, last_y = '0, last_z = '0;
   int          burst_left = 0;
   bit          no_gaps = 1'b0;
   int          n_sent = 0;
   int          n_settings = 0;

   // response-side stall generator state
   rdy_mode_type rdy_mode = RDY_ALWAYS;
   int           rdy_left = 0;
   logic [7:0]   rdy_pat = 8'hB3;

   grid_bucket_offset_index_core u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   gboi_resp_checker u_chk (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .fail_count  (n_fail),
      .pending     (n_due),
      .checked     (n_checked),
      .full_seen   (n_full)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Response stalls: pick a new mode whenever rdy_left runs out. Modes cover
   // always ready, coin flip, mostly ready, and a rotating bit pattern.
   always @(negedge clock) begin
      if (rdy_left == 0) begin
         rdy_mode = rdy_mode_type'($urandom_range(3, 0));
         rdy_left = $urandom_range(80, 16);
         if (rdy_mode == RDY_PATTERN)
            rdy_pat = 8'($urandom_range(255, 1));
      end
      rdy_left--;
      case (rdy_mode)
         RDY_ALWAYS: rsp_ready <= 1'b1;
         RDY_COIN:   rsp_ready <= 1'($urandom_range(1, 0));
         RDY_MOSTLY: rsp_ready <= ($urandom_range(4, 0) != 0);
         default: begin
            rdy_pat = {rdy_pat[6:0], rdy_pat[7]};
            rsp_ready <= rdy_pat[0];
         end
      endcase
   end

   function automatic req_type mk_req(input logic [KIND_W-1:0] k,
                                      input logic [3:0] x, input logic [3:0] y,
                                      input logic [3:0] z);
      req_type rq;
      rq.kind  = k;
      rq.loc_x = x;
      rq.loc_y = y;
      rq.loc_z = z;
      return rq;
   endfunction

   // mostly inside the current extent, sometimes anywhere on the 4-bit field
   function automatic logic [3:0] pick_coord(input int ext);
      if (ext > 0 && $urandom_range(99, 0) < 85)
         return 4'($urandom_range(ext - 1, 0));
      return 4'($urandom_range(15, 0));
   endfunction

   function automatic int sat_extent(input logic [SIZE_W-1:0] v);
      return (v > DIM_MAX_DEF) ? DIM_MAX_DEF : int'(v);
   endfunction

   // Random beat: adds and queries dominate, some queries go back to the
   // last added cell so they hit a filled bucket; clears kept rare since
   // each one sweeps the whole table.
   function automatic req_type rand_req();
      req_type rq;
      int      roll;
      roll = $urandom_range(99, 0);
      rq = mk_req(KIND_QUERY, pick_coord(eff_x), pick_coord(eff_y), pick_coord(eff_z));
      if (roll >= 40 && roll < 75) begin
         rq.kind = KIND_ADD;
         last_x = rq.loc_x;
         last_y = rq.loc_y;
         last_z = rq.loc_z;
      end else if (roll >= 75 && roll < 79) begin
         rq.kind = KIND_CLEAR;
      end else if (roll >= 79 && roll < 85) begin
         rq.kind = KIND_UNUSED;
      end else if (roll >= 85) begin
         rq.loc_x = last_x;
         rq.loc_y = last_y;
         rq.loc_z = last_z;
      end
      return rq;
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat
   // is taken. Between bursts valid may drop for a random gap.
   task automatic send_beat(input req_type rq);
      int gap;
      if (burst_left == 0) begin
         gap = (no_gaps || $urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(8, 1);
      end
      req_payload <= rq;
      req_valid   <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      burst_left--;
      n_sent++;
   endtask

   // drop valid, wait for every due response, then extra quiet cycles
   task automatic wait_results(input int extra);
      req_valid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (n_due != 0);
      repeat (extra) @(negedge clock);
   endtask

   // only while idle; raw values so zero and saturation reach the block
   task automatic set_extents(input logic [SIZE_W-1:0] x, input logic [SIZE_W-1:0] y,
                              input logic [SIZE_W-1:0] z);
      csr_we    <= 1'b1;
      csr_index <= CSR_SIZE_X;
      csr_wdata <= x;
      @(negedge clock);
      csr_index <= CSR_SIZE_Y;
      csr_wdata <= y;
      @(negedge clock);
      csr_index <= CSR_SIZE_Z;
      csr_wdata <= z;
      @(negedge clock);
      csr_we <= 1'b0;
      eff_x = sat_extent(x);
      eff_y = sat_extent(y);
      eff_z = sat_extent(z);
      n_settings++;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // -- directed, reset extents 1x1x1 --------------------------------
      // first beat waits out the clearing pass on req_ready
      send_beat(mk_req(KIND_QUERY, 4'd0, 4'd0, 4'd0));    // empty table
      send_beat(mk_req(KIND_ADD, 4'd0, 4'd0, 4'd0));
      send_beat(mk_req(KIND_ADD, 4'd0, 4'd0, 4'd0));
      send_beat(mk_req(KIND_QUERY, 4'd0, 4'd0, 4'd0));    // two entries
      send_beat(mk_req(KIND_ADD, 4'd1, 4'd0, 4'd0));      // x out of range
      send_beat(mk_req(KIND_QUERY, 4'd15, 4'd15, 4'd15)); // out of range
      send_beat(mk_req(KIND_UNUSED, 4'd15, 4'd15, 4'd15));
      send_beat(mk_req(KIND_CLEAR, 4'd15, 4'd15, 4'd15));
      send_beat(mk_req(KIND_QUERY, 4'd0, 4'd0, 4'd0));    // empty again
      wait_results(TAIL_CYCLES);

      // full grid: first and last cell
      set_extents(5'd16, 5'd16, 5'd16);
      send_beat(mk_req(KIND_ADD, 4'd15, 4'd15, 4'd15));
      send_beat(mk_req(KIND_ADD, 4'd0, 4'd0, 4'd0));
      send_beat(mk_req(KIND_QUERY, 4'd15, 4'd15, 4'd15));
      send_beat(mk_req(KIND_QUERY, 4'd0, 4'd0, 4'd0));
      send_beat(mk_req(KIND_QUERY, 4'd8, 4'd4, 4'd2));
      wait_results(TAIL_CYCLES);

      // saturated x and z, zero y: nothing is in range
      set_extents(5'd31, 5'd0, 5'd17);
      send_beat(mk_req(KIND_QUERY, 4'd0, 4'd0, 4'd0));
      send_beat(mk_req(KIND_ADD, 4'd3, 4'd0, 4'd5));
      send_beat(mk_req(KIND_QUERY, 4'd15, 4'd15, 4'd15));
      wait_results(TAIL_CYCLES);

      // new extents over the old table: same linear slots, new meaning
      set_extents(5'd8, 5'd8, 5'd8);
      send_beat(mk_req(KIND_QUERY, 4'd7, 4'd7, 4'd7));
      send_beat(mk_req(KIND_QUERY, 4'd0, 4'd0, 4'd0));
      send_beat(mk_req(KIND_CLEAR, 4'd0, 4'd0, 4'd0));
      wait_results(TAIL_CYCLES);

      // -- top-row adds --------------------------------------------------
      // Adds in the top row (c >= 4080) keep each sweep short.
      set_extents(5'd16, 5'd16, 5'd16);
      for (int i = 0; i < FILL_ADDS; i++) begin
         send_beat(mk_req(KIND_ADD, 4'($urandom_range(15, 0)), 4'd15, 4'd15));
         if (i % 4 == 3)
            send_beat(mk_req(KIND_QUERY, 4'($urandom_range(15, 0)), 4'd15, 4'd15));
      end
      send_beat(mk_req(KIND_QUERY, 4'd15, 4'd15, 4'd15));
      send_beat(mk_req(KIND_QUERY, 4'd0, 4'd15, 4'd15));
      wait_results(TAIL_CYCLES);

      // narrower x over the same table: out-of-range add, in-range add
      set_extents(5'd8, 5'd16, 5'd16);
      send_beat(mk_req(KIND_ADD, 4'd12, 4'd15, 4'd15));
      send_beat(mk_req(KIND_ADD, 4'd7, 4'd15, 4'd15));
      send_beat(mk_req(KIND_QUERY, 4'd7, 4'd15, 4'd15));
      send_beat(mk_req(KIND_CLEAR, 4'd0, 4'd0, 4'd0));
      wait_results(TAIL_CYCLES);

      // -- random phases ------------------------------------------------
      for (int p = 0; p < RAND_PHASES; p++) begin
         case (p)
            0: set_extents(5'd16, 5'd16, 5'd16);
            1: set_extents(5'd1, 5'd1, 5'd1);
            2: set_extents(5'd4, 5'd3, 5'd2);
            3: set_extents(5'($urandom_range(16, 1)), 5'($urandom_range(16, 1)),
                           5'($urandom_range(16, 1)));
            default: set_extents(5'($urandom_range(31, 0)), 5'($urandom_range(31, 0)),
                                 5'($urandom_range(31, 0)));
         endcase
         no_gaps = (p == 2);  // one phase runs back to back
         for (int k = 0; k < RAND_ITEMS; k++) begin
            // hold off mid-phase until the block has drained
            if (p == 1 && k == RAND_ITEMS / 2)
               wait_results(0);
            send_beat(rand_req());
         end
         wait_results(TAIL_CYCLES);
      end

      $display("covered %0d request beats over %0d extent settings, %0d responses checked",
               n_sent, n_settings, n_checked);
      $display("%0d adds refused on a full table, %0d mismatches", n_full, n_fail);
      if (n_fail == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Worst case: ~140 beats, each a full-table sweep plus stalls and gaps;
   // the timeout allows several times that.
   initial begin
      #40_000_000;
      $display("timeout with %0d responses still due", n_due);
      $display("== FAIL ==");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+design
design/gboi_pkg.sv
design/gboi_front.sv
design/gboi_queue.sv
design/gboi_back.sv
design/grid_bucket_offset_index_core.sv
sim/gboi_resp_checker.sv
sim/grid_bucket_offset_index_core_test.sv
